FILE: rtl/cv3_pkg.sv
// Shared types, constants and tap tables for the 3x3 convolution line-buffer block.
`default_nettype none

package cv3_pkg;

    localparam int MAX_WIDTH    = 512;
    localparam int HEIGHT_LIMIT = 512;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int SIZE_W       = 10;
    localparam int NUM_TAPS     = 9;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    localparam logic [SIZE_W-1:0] RESET_SIZE = 10'd416;

    typedef enum logic [1:0] {
        CMD_WEIGHT = 2'd0,
        CMD_BIAS   = 2'd1,
        CMD_PIXEL  = 2'd2,
        CMD_DRAIN  = 2'd3
    } cmd_t;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } border_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [3:0]          widx;
        logic signed [15:0]  sample;
        logic signed [31:0]  bias;
        logic                last_ch;
        logic signed [31:0]  psum;
        logic [COL_W-1:0]    col;
        logic                have_out;
        border_t             border;
        logic                last;
    } item_t;

    // Weight word used by each window tap, and the tap's row and column
    localparam logic [3:0] WEIGHT_OF [0:NUM_TAPS-1] =
        '{4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8};
    localparam logic [1:0] TAP_ROW [0:NUM_TAPS-1] =
        '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};
    localparam logic [1:0] TAP_COL [0:NUM_TAPS-1] =
        '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2};

endpackage

`default_nettype wire

FILE: rtl/cv3_front.sv
// Front end: configuration registers, stream position tracking and item classification.
`default_nettype none

module cv3_front
    import cv3_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    input  wire logic               in_valid,
    input  wire logic [1:0]         command,
    input  wire logic [3:0]         weight_index,
    input  wire logic signed [15:0] sample,
    input  wire logic signed [31:0] bias_value,
    input  wire logic               last_channel,
    input  wire logic signed [31:0] partial_sum,
    input  wire logic               q_full,
    output logic                    push,
    output item_t                   push_item
);

    logic [SIZE_W-1:0] width_reg, width_next;
    logic [SIZE_W-1:0] height_reg, height_next;
    logic [SIZE_W-1:0] in_row_reg, in_row_next;
    logic [SIZE_W-1:0] in_col_reg, in_col_next;
    logic [SIZE_W-1:0] eff_w, eff_h, c, col_inc, qr, qc;
    logic              cfg_wr, have, last, stream;
    border_t           border;
    cmd_t              cmd;

    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (reg_idx_t'(paddr[2]) == REG_HEIGHT) ? {22'd0, height_reg}
                                                       : {22'd0, width_reg};
    assign cmd    = cmd_t'(command);
    assign stream = (cmd == CMD_PIXEL) || (cmd == CMD_DRAIN);
    assign push   = in_valid && !q_full;

    always_comb
    begin
        eff_w = width_reg;
        if (width_reg == '0)
            eff_w = SIZE_W'(1);
        else if (int'(width_reg) > MAX_WIDTH)
            eff_w = SIZE_W'(MAX_WIDTH);
        eff_h = height_reg;
        if (height_reg == '0)
            eff_h = SIZE_W'(1);
        else if (int'(height_reg) > HEIGHT_LIMIT)
            eff_h = SIZE_W'(HEIGHT_LIMIT);

        c = (in_col_reg >= eff_w) ? eff_w - SIZE_W'(1) : in_col_reg;
        if (c == '0)
        begin
            have = in_row_reg >= SIZE_W'(2);
            qr   = in_row_reg - SIZE_W'(2);
            qc   = eff_w - SIZE_W'(1);
        end
        else
        begin
            have = in_row_reg >= SIZE_W'(1);
            qr   = in_row_reg - SIZE_W'(1);
            qc   = c - SIZE_W'(1);
        end
        have          = have && (qr < eff_h);
        border.top    = (qr == '0);
        border.bottom = (qr == eff_h - SIZE_W'(1));
        border.left   = (qc == '0);
        border.right  = (qc == eff_w - SIZE_W'(1));
        last          = have && border.bottom && border.right;
        col_inc       = c + SIZE_W'(1);

        push_item          = '0;
        push_item.cmd      = cmd;
        push_item.widx     = weight_index;
        push_item.sample   = (cmd == CMD_DRAIN) ? 16'sd0 : sample;
        push_item.bias     = bias_value;
        push_item.last_ch  = last_channel;
        push_item.psum     = partial_sum;
        push_item.col      = COL_W'(c);
        push_item.have_out = have;
        push_item.border   = border;
        push_item.last     = last;

        width_next  = width_reg;
        height_next = height_reg;
        in_row_next = in_row_reg;
        in_col_next = in_col_reg;
        if (cfg_wr)
        begin
            if (reg_idx_t'(paddr[2]) == REG_HEIGHT)
                height_next = pwdata[SIZE_W-1:0];
            else
                width_next = pwdata[SIZE_W-1:0];
            in_row_next = '0;
            in_col_next = '0;
        end
        else if (push && stream)
        begin
            if (last)
            begin
                in_row_next = '0;
                in_col_next = '0;
            end
            else if (col_inc >= eff_w)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + SIZE_W'(1);
            end
            else
                in_col_next = col_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_SIZE;
            height_reg <= RESET_SIZE;
            in_row_reg <= '0;
            in_col_reg <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            in_row_reg <= in_row_next;
            in_col_reg <= in_col_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/cv3_queue.sv
// Short register queue that decouples the front end from the back end.
`default_nettype none

module cv3_queue
    import cv3_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  item_t      push_item,
    output logic       full,
    output logic       valid,
    output item_t      head,
    input  wire logic  pop
);

    item_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + (QPTR_W+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (QPTR_W+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/cv3_back.sv
// Back end: line memories, window, weight and bias registers, multiply and sum pipeline.
`default_nettype none

module cv3_back
    import cv3_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    input  item_t              q_item,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic signed [31:0] sum,
    output logic               plane_end
);

    localparam logic signed [35:0] SUM_MAX = 36'sh07FFFFFFF;
    localparam logic signed [35:0] SUM_MIN = -36'sh080000000;

    logic [15:0] mem_a [MAX_WIDTH];
    logic [15:0] mem_b [MAX_WIDTH];

    logic               en;
    logic               s1_valid_reg;
    item_t              s1_reg;
    logic               s1_stream;
    logic [15:0]        rd_a_reg, rd_b_reg, wr_a_reg, wr_b_reg;
    logic               fwd_reg;
    logic signed [15:0] a_eff, b_eff;
    logic signed [15:0] window_reg [NUM_TAPS];
    logic signed [15:0] win_next   [NUM_TAPS];
    logic signed [15:0] weights_reg [NUM_TAPS];
    logic signed [31:0] bias_reg;
    logic               bias_en_reg;

    logic               s2_valid_reg, s2_last_reg;
    logic signed [31:0] prod_reg [NUM_TAPS];
    logic signed [31:0] prod_next [NUM_TAPS];
    logic signed [32:0] pb2_reg, pb_next;

    logic               s3_valid_reg, s3_last_reg;
    logic signed [33:0] grp_reg [3];
    logic signed [32:0] pb3_reg;
    logic signed [35:0] total;

    logic               out_valid_reg, out_last_reg;
    logic signed [31:0] out_sum_reg;

    assign en        = !out_valid_reg || !out_stall;
    assign pop       = q_valid && en;
    assign s1_stream = (s1_reg.cmd == CMD_PIXEL) || (s1_reg.cmd == CMD_DRAIN);
    assign out_valid = out_valid_reg;
    assign sum       = out_sum_reg;
    assign plane_end = out_last_reg;

    // Take the value the item just ahead wrote when it hit the same column
    assign a_eff = fwd_reg ? wr_a_reg : rd_a_reg;
    assign b_eff = fwd_reg ? wr_b_reg : rd_b_reg;

    always_comb
    begin
        logic masked;
        for (int r = 0; r < 3; r++)
        begin
            win_next[r*3+0] = window_reg[r*3+1];
            win_next[r*3+1] = window_reg[r*3+2];
        end
        win_next[2] = b_eff;
        win_next[5] = a_eff;
        win_next[8] = s1_reg.sample;
        for (int k = 0; k < NUM_TAPS; k++)
        begin
            masked = ((TAP_ROW[k] == 2'd0) && s1_reg.border.top)
                  || ((TAP_ROW[k] == 2'd2) && s1_reg.border.bottom)
                  || ((TAP_COL[k] == 2'd0) && s1_reg.border.left)
                  || ((TAP_COL[k] == 2'd2) && s1_reg.border.right);
            prod_next[k] = masked ? 32'sd0 : win_next[k] * weights_reg[WEIGHT_OF[k]];
        end
        pb_next = 33'(s1_reg.psum) + (bias_en_reg ? 33'(bias_reg) : 33'sd0);
        total = 36'(grp_reg[0]) + 36'(grp_reg[1]) + 36'(grp_reg[2]) + 36'(pb3_reg);
    end

    // Line memories: read on pop, write back as the item leaves the first stage
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rd_a_reg <= mem_a[q_item.col];
            rd_b_reg <= mem_b[q_item.col];
        end
        if (en && s1_valid_reg && s1_stream)
        begin
            mem_a[s1_reg.col] <= s1_reg.sample;
            mem_b[s1_reg.col] <= a_eff;
            wr_a_reg          <= s1_reg.sample;
            wr_b_reg          <= a_eff;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (pop)
                s1_reg <= q_item;
            s2_last_reg <= s1_reg.last;
            pb2_reg     <= pb_next;
            for (int k = 0; k < NUM_TAPS; k++)
                prod_reg[k] <= prod_next[k];
            s3_last_reg <= s2_last_reg;
            pb3_reg     <= pb2_reg;
            for (int m = 0; m < 3; m++)
                grp_reg[m] <= 34'(prod_reg[m*3]) + 34'(prod_reg[m*3+1])
                            + 34'(prod_reg[m*3+2]);
            out_last_reg <= s3_last_reg;
            if (total > SUM_MAX)
                out_sum_reg <= SUM_MAX[31:0];
            else if (total < SUM_MIN)
                out_sum_reg <= SUM_MIN[31:0];
            else
                out_sum_reg <= total[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_reg       <= 1'b0;
            bias_reg      <= '0;
            bias_en_reg   <= 1'b0;
            for (int k = 0; k < NUM_TAPS; k++)
            begin
                window_reg[k]  <= '0;
                weights_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            s1_valid_reg  <= pop;
            fwd_reg       <= pop && s1_valid_reg && s1_stream && (s1_reg.col == q_item.col);
            s2_valid_reg  <= s1_valid_reg && s1_stream && s1_reg.have_out;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
            if (s1_valid_reg)
            begin
                case (s1_reg.cmd)
                    CMD_WEIGHT:
                    begin
                        if (s1_reg.widx < 4'(NUM_TAPS))
                            weights_reg[s1_reg.widx] <= s1_reg.sample;
                    end
                    CMD_BIAS:
                    begin
                        bias_reg    <= s1_reg.bias;
                        bias_en_reg <= s1_reg.last_ch;
                    end
                    default:
                    begin
                        for (int k = 0; k < NUM_TAPS; k++)
                            window_reg[k] <= win_next[k];
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/conv2d_3x3_same_line_buffer.sv
// Top level of the streaming 3x3 same-padded convolution pass.
// A result passes from its causing transfer through the queue, s1, s2, s3 and output registers.
// Throughput: one item per cycle absent result stalls, set by one read and one write per line memory.
// Reset: clears position, window, weights and bias; the line memories need no clearing pass,
// since every window entry outside the plane is masked and the rest are written first.
`default_nettype none

module conv2d_3x3_same_line_buffer
    import cv3_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // input channel
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         command,
    input  wire logic [3:0]         weight_index,
    input  wire logic signed [15:0] sample,
    input  wire logic signed [31:0] bias_value,
    input  wire logic               last_channel,
    input  wire logic signed [31:0] partial_sum,
    // result channel
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      sum,
    output logic                    plane_end
);

    logic  q_full, q_valid, push, pop;
    item_t push_item, q_head;

    // Writes complete without wait states
    assign pready   = 1'b1;
    // Hold the input side only while the queue is full
    assign in_stall = q_full;

    // Classify each transfer and advance the stream position
    cv3_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .in_valid     (in_valid),
        .command      (command),
        .weight_index (weight_index),
        .sample       (sample),
        .bias_value   (bias_value),
        .last_channel (last_channel),
        .partial_sum  (partial_sum),
        .q_full       (q_full),
        .push         (push),
        .push_item    (push_item)
    );

    // Buffer classified items so either side can stall independently
    cv3_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .valid     (q_valid),
        .head      (q_head),
        .pop       (pop)
    );

    // Execute loads, shift the window and produce the saturated sum
    cv3_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sum       (sum),
        .plane_end (plane_end)
    );

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the streaming 3x3 same-padded convolution pass.
`default_nettype none

module tb;
    import cv3_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY_GAP = 12;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         command;
    logic [3:0]         weight_index;
    logic signed [15:0] sample;
    logic signed [31:0] bias_value;
    logic               last_channel;
    logic signed [31:0] partial_sum;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] sum;
    logic               plane_end;

    conv2d_3x3_same_line_buffer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .weight_index (weight_index),
        .sample       (sample),
        .bias_value   (bias_value),
        .last_channel (last_channel),
        .partial_sum  (partial_sum),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sum          (sum),
        .plane_end    (plane_end)
    );

    // Predicted results waiting for their transfer on the result channel
    typedef struct packed {
        logic signed [31:0] sum;
        logic               plane_end;
    } conv_out_t;

    conv_out_t conv_pending[$];

    // Shadow of the block's state
    logic [9:0]         mdl_width;
    logic [9:0]         mdl_height;
    logic [15:0]        mdl_lines[2*MAX_WIDTH];
    logic [15:0]        mdl_win[9];
    logic [15:0]        mdl_wts[9];
    logic signed [31:0] mdl_bias;
    logic               mdl_bias_en;
    int unsigned        mdl_row;
    int unsigned        mdl_col;

    int unsigned mismatches;
    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned planes_seen;

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Generous ceiling: a wedged handshake must still end the run
    initial
    begin
        #4ms;
        $display("timeout waiting for transfers");
        $display("end of test: mismatches");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    function automatic int unsigned eff_width();
        if (mdl_width == 0) return 1;
        if (mdl_width > MAX_WIDTH) return MAX_WIDTH;
        return mdl_width;
    endfunction

    function automatic int unsigned eff_height();
        if (mdl_height == 0) return 1;
        if (mdl_height > HEIGHT_LIMIT) return HEIGHT_LIMIT;
        return mdl_height;
    endfunction

    task automatic shadow_reset();
        mdl_width   = RESET_SIZE;
        mdl_height  = RESET_SIZE;
        mdl_bias    = '0;
        mdl_bias_en = 1'b0;
        mdl_row     = 0;
        mdl_col     = 0;
        foreach (mdl_lines[i]) mdl_lines[i] = '0;
        foreach (mdl_win[i]) mdl_win[i] = '0;
        foreach (mdl_wts[i]) mdl_wts[i] = '0;
    endtask

    // Advance the shadow for one accepted item and queue any result it causes
    task automatic predict_conv(input cmd_t cmd, input logic [3:0] widx,
                                input logic signed [15:0] smp,
                                input logic signed [31:0] bias,
                                input logic lastc, input logic signed [31:0] psum);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned qr;
        int unsigned qc;
        bit          emit;
        logic [15:0] pix;
        longint      acc;
        conv_out_t   res;
        w = eff_width();
        h = eff_height();
        emit = 1'b0;
        qr = 0;
        qc = 0;
        case (cmd)
            CMD_WEIGHT:
            begin
                if (widx < NUM_TAPS) mdl_wts[widx] = smp;
                return;
            end
            CMD_BIAS:
            begin
                mdl_bias    = bias;
                mdl_bias_en = lastc;
                return;
            end
            default: ;
        endcase
        pix = (cmd == CMD_PIXEL) ? smp : 16'd0;
        c = (mdl_col >= w) ? w - 1 : mdl_col;
        for (int r = 0; r < 3; r++)
        begin
            mdl_win[r*3]   = mdl_win[r*3+1];
            mdl_win[r*3+1] = mdl_win[r*3+2];
        end
        mdl_win[2] = mdl_lines[MAX_WIDTH + c];
        mdl_win[5] = mdl_lines[c];
        mdl_win[8] = pix;
        mdl_lines[MAX_WIDTH + c] = mdl_lines[c];
        mdl_lines[c] = pix;
        // column zero closes the previous row's last output
        if (c == 0)
        begin
            if (mdl_row >= 2)
            begin
                qr = mdl_row - 2;
                qc = w - 1;
                emit = 1'b1;
            end
        end
        else if (mdl_row >= 1)
        begin
            qr = mdl_row - 1;
            qc = c - 1;
            emit = 1'b1;
        end
        if (emit && qr >= h) emit = 1'b0;
        mdl_col = c + 1;
        if (mdl_col >= w)
        begin
            mdl_col = 0;
            mdl_row++;
        end
        if (!emit) return;
        acc = longint'(psum);
        for (int k = 0; k < 9; k++)
        begin
            int i;
            int j;
            i = k / 3;
            j = k % 3;
            // mask taps in the zero padding
            if (i == 0 && qr == 0) continue;
            if (i == 2 && qr == h - 1) continue;
            if (j == 0 && qc == 0) continue;
            if (j == 2 && qc == w - 1) continue;
            acc += longint'($signed(mdl_win[k])) * longint'($signed(mdl_wts[j*3+i]));
        end
        if (mdl_bias_en) acc += longint'(mdl_bias);
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        res.sum = acc[31:0];
        res.plane_end = (qr == h - 1) && (qc == w - 1);
        if (res.plane_end)
        begin
            mdl_row = 0;
            mdl_col = 0;
        end
        conv_pending.push_back(res);
    endtask

    // Send one item: random gap, then hold valid until the transfer;
    // valid stays up for the next item or an idle period to drop
    task automatic send_item(input cmd_t cmd, input logic [3:0] widx,
                             input logic signed [15:0] smp,
                             input logic signed [31:0] bias,
                             input logic lastc, input logic signed [31:0] psum,
                             input bit no_gap = 1'b0);
        int unsigned gap;
        gap = no_gap ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        weight_index <= widx;
        sample       <= smp;
        bias_value   <= bias;
        last_channel <= lastc;
        partial_sum  <= psum;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_conv(cmd, widx, smp, bias, lastc, psum);
        items_sent++;
    endtask

    task automatic send_pixel(input logic signed [15:0] smp, input bit no_gap = 1'b0);
        send_item(CMD_PIXEL, 4'($urandom), smp, $urandom, 1'($urandom), $urandom, no_gap);
    endtask

    task automatic send_drain(input logic signed [31:0] psum);
        send_item(CMD_DRAIN, 4'($urandom), 16'($urandom), $urandom, 1'($urandom), psum);
    endtask

    task automatic load_weight(input logic [3:0] widx, input logic signed [15:0] val);
        send_item(CMD_WEIGHT, widx, val, $urandom, 1'($urandom), $urandom);
    endtask

    task automatic load_bias(input logic signed [31:0] val, input logic lastc);
        send_item(CMD_BIAS, 4'($urandom), 16'($urandom), val, lastc, $urandom);
    endtask

    // Drop the input, hold off until every expected result has left, then let the pipe empty
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (conv_pending.size() != 0) @(posedge clk);
        repeat (LATENCY_GAP) @(posedge clk);
    endtask

    // APB write: setup then access; pready is tied high
    task automatic write_reg(input reg_idx_t idx, input logic [9:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(idx) << 2;
        pwdata  <= 32'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_WIDTH) mdl_width = val;
        else mdl_height = val;
        mdl_row = 0;
        mdl_col = 0;
        // an idle bus state before anything else drives the port
        @(posedge clk);
    endtask

    task automatic set_size(input logic [9:0] w, input logic [9:0] h);
        wait_idle();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'($urandom_range(0, 1024)) - 16'sd512;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_psum();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    // One full plane: pixels then width+1 drains; with mixed_tail, a few drains swapped for pixels
    task automatic stream_plane(input bit mixed_tail);
        int unsigned w;
        int unsigned h;
        w = eff_width();
        h = eff_height();
        for (int unsigned p = 0; p < w * h; p++)
            send_pixel(rand_sample(), $urandom_range(0, 3) == 0);
        for (int unsigned p = 0; p <= w; p++)
        begin
            if (mixed_tail && $urandom_range(0, 2) == 0)
                send_item(CMD_PIXEL, 4'($urandom), rand_sample(), $urandom, 1'($urandom),
                          rand_psum());
            else
                send_drain(rand_psum());
        end
    endtask

    task automatic load_random_kernel();
        for (int i = 0; i < NUM_TAPS; i++) load_weight(4'(i), rand_sample());
        load_bias($urandom, 1'($urandom));
    endtask

    // Extremes of weights, samples, bias and sums to drive saturation both ways
    task automatic test_directed();
        set_size(10'd3, 10'd2);
        for (int i = 0; i < NUM_TAPS; i++) load_weight(4'(i), 16'sh8000);
        load_weight(4'd15, 16'sh1234);      // out-of-range index: ignored
        load_weight(4'd9, 16'sh7fff);       // out-of-range index: ignored
        load_bias(32'sh7fffffff, 1'b1);
        for (int p = 0; p < 6; p++) send_pixel((p % 2) ? 16'sh7fff : 16'sh8000);
        for (int p = 0; p < 4; p++) send_drain(32'sh7fffffff);
        load_bias(32'sh80000000, 1'b0);
        for (int p = 0; p < 6; p++) send_pixel(16'sh8000);
        for (int p = 0; p < 4; p++) send_drain(32'sh80000000);
    endtask

    // Smallest planes: width and height of one, zero read as one, and single rows and columns
    task automatic test_tiny_planes();
        set_size(10'd1, 10'd1);
        load_random_kernel();
        repeat (3) stream_plane(1'b0);
        set_size(10'd0, 10'd0);
        repeat (3) stream_plane(1'b1);
        set_size(10'd1, 10'd5);
        stream_plane(1'b0);
        set_size(10'd7, 10'd1);
        stream_plane(1'b1);
    endtask

    // Oversized registers clamp; only one wide row, since planes grow fast
    task automatic test_clamped_sizes();
        set_size(10'd1023, 10'd1);
        load_random_kernel();
        stream_plane(1'b0);
        set_size(10'd2, 10'd1023);
        // feed a partial plane then cut it short with a register write
        for (int p = 0; p < 40; p++) send_pixel(rand_sample());
        set_size(10'd5, 10'd3);
        stream_plane(1'b1);
    endtask

    // Random small planes, kernels reloaded between planes, stale buffers reused
    task automatic test_random_planes();
        while (items_sent < 1700)
        begin
            if ($urandom_range(0, 3) == 0)
                set_size(10'($urandom_range(1, 9)), 10'($urandom_range(1, 9)));
            if ($urandom_range(0, 1) == 0) load_random_kernel();
            else if ($urandom_range(0, 1) == 0)
                load_weight(4'($urandom), rand_sample());
            stream_plane($urandom_range(0, 3) == 0);
        end
    endtask

    // Result side: random stall per result, then compare with the oldest prediction
    initial
    begin
        int unsigned hold;
        conv_out_t   exp_res;
        out_stall <= 1'b1;
        @(posedge rst_n);
        forever
        begin
            hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            results_seen++;
            if (conv_pending.size() == 0)
                report_mismatch($sformatf("unexpected result sum=%h", sum));
            else
            begin
                exp_res = conv_pending.pop_front();
                if (sum !== exp_res.sum)
                    report_mismatch($sformatf("sum %h, predicted %h", sum, exp_res.sum));
                if (plane_end !== exp_res.plane_end)
                    report_mismatch($sformatf("plane_end %b, predicted %b",
                                              plane_end, exp_res.plane_end));
                if (exp_res.plane_end) planes_seen++;
            end
        end
    end

    initial
    begin
        mismatches   = 0;
        items_sent   = 0;
        results_seen = 0;
        planes_seen  = 0;
        shadow_reset();
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        command      = CMD_PIXEL;
        weight_index = '0;
        sample       = '0;
        bias_value   = '0;
        last_channel = 1'b0;
        partial_sum  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_tiny_planes();
        test_clamped_sizes();
        test_random_planes();

        // drain the pipeline before judging
        wait_idle();
        $display("covered %0d items, %0d results, %0d planes; sizes 0..1023, saturation",
                 items_sent, results_seen, planes_seen);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
